// ----- design/rlwfq_pkg.sv -----
package rlwfq_pkg;

   localparam int ENTRIES   = 6;
   localparam int IDX_W     = $clog2(ENTRIES);
   localparam int SLOT_BITS = 10;
   localparam int TABLE_W   = 60;
   localparam int TIME_W    = 32;
   localparam int RSP_W     = 8;

   localparam logic [TABLE_W-1:0] INC_RESET    = 60'd144143803564163136;
   localparam logic [TABLE_W-1:0] PERIOD_RESET = 60'd564049573472870650;

   typedef enum logic [0:0] {
      REG_INCREMENT  = 1'b0,
      REG_MIN_PERIOD = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic             start;
      logic             scan;
      logic             commit;
      logic [IDX_W-1:0] idx;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

// ----- design/rate_limited_wfq_picker.sv -----
// A transaction is accepted in the idle state; in the scan state the single comparator
// walks the entries, and the finish state updates the winner, if any, once the output is free.
// No new transaction is accepted until the finish state has committed its result.
// A waiting result does not stop the next transaction from being accepted.
// Reset (synchronous, active high) clears all entries to never sent and zero
// times, and loads the default increment and minimum period tables.
module rate_limited_wfq_picker
   import rlwfq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [TIME_W-1:0]  req_tdata,   // now_ms
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RSP_W-1:0]   rsp_tdata,   // granted, entry_index[2:0], zero padding
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [TABLE_W-1:0] csr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   rlwfq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rlwfq_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .now_ms     (req_tdata),
      .csr_write  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- design/rlwfq_ctrl.sv -----
module rlwfq_ctrl
   import rlwfq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type        state_ff;
   logic [IDX_W-1:0] idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               idx_ff <= '0;
               if (req_tvalid) begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (idx_ff == IDX_W'(ENTRIES - 1)) begin
                  state_ff <= ST_FINISH;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_FINISH: begin
               if (status.out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      cmd.start  = (state_ff == ST_IDLE) && req_tvalid;
      cmd.scan   = (state_ff == ST_SCAN);
      cmd.commit = (state_ff == ST_FINISH) && status.out_free;
      cmd.idx    = idx_ff;
   end

endmodule

// ----- design/rlwfq_dp.sv -----
module rlwfq_dp
   import rlwfq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   output dp_status_type      status,
   input  logic [TIME_W-1:0]  now_ms,
   input  logic               csr_write,
   input  logic               csr_index,
   input  logic [TABLE_W-1:0] csr_data,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RSP_W-1:0]   rsp_tdata
);

   logic [TABLE_W-1:0] inc_table_ff;
   logic [TABLE_W-1:0] period_table_ff;

   logic [TIME_W-1:0]  finish_ff [ENTRIES];
   logic [TIME_W-1:0]  last_ff   [ENTRIES];
   logic [ENTRIES-1:0] sent_ff;

   logic [TIME_W-1:0]  now_ff;
   logic               found_ff;
   logic [IDX_W-1:0]   best_ff;
   logic [TIME_W-1:0]  best_finish_ff;

   logic               rsp_valid_ff;
   logic               granted_ff;
   logic [IDX_W-1:0]   index_ff;

   logic [SLOT_BITS-1:0] period_slot;
   logic [SLOT_BITS-1:0] inc_slot;
   logic [TIME_W-1:0]    elapsed;
   logic                 eligible;
   logic                 take;
   logic [TIME_W:0]      sum;
   logic [TIME_W-1:0]    sat_sum;

   assign period_slot = period_table_ff[SLOT_BITS*cmd.idx +: SLOT_BITS];
   assign inc_slot    = inc_table_ff[SLOT_BITS*best_ff +: SLOT_BITS];
   assign elapsed     = now_ff - last_ff[cmd.idx];
   assign eligible    = !sent_ff[cmd.idx] || (elapsed >= TIME_W'(period_slot));
   assign take        = eligible && (!found_ff || (finish_ff[cmd.idx] < best_finish_ff));
   assign sum         = {1'b0, best_finish_ff} + (TIME_W + 1)'(inc_slot);
   assign sat_sum     = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];

   assign status.out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         inc_table_ff    <= INC_RESET;
         period_table_ff <= PERIOD_RESET;
      end else if (csr_write) begin
         unique case (csr_reg_type'(csr_index))
            REG_INCREMENT:  inc_table_ff    <= csr_data;
            REG_MIN_PERIOD: period_table_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         now_ff   <= now_ms;
         found_ff <= 1'b0;
      end else if (cmd.scan && take) begin
         found_ff       <= 1'b1;
         best_ff        <= cmd.idx;
         best_finish_ff <= finish_ff[cmd.idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            finish_ff[i] <= '0;
            last_ff[i]   <= '0;
         end
         sent_ff <= '0;
      end else if (cmd.commit && found_ff) begin
         finish_ff[best_ff] <= sat_sum;
         last_ff[best_ff]   <= now_ff;
         sent_ff[best_ff]   <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         granted_ff <= found_ff;
         index_ff   <= found_ff ? best_ff : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({index_ff, granted_ff});

endmodule

// ----- design/rlwfq_checker.sv -----
module rlwfq_checker
   import rlwfq_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_tvalid,
   input logic               req_tready,
   input logic               rsp_tvalid,
   input logic               rsp_tready,
   input logic [RSP_W-1:0]   rsp_tdata
);

   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata);
   endproperty
   assert property (p_rsp_hold) else $error("Result changed while stalled.");

   property p_no_grant_zero_index;
      @(posedge clock) disable iff (reset)
         rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[3:1] == 3'd0;
   endproperty
   assert property (p_no_grant_zero_index) else $error("Index set without a grant.");

   property p_index_range;
      @(posedge clock) disable iff (reset)
         rsp_tvalid |-> rsp_tdata[3:1] < 3'(ENTRIES);
   endproperty
   assert property (p_index_range) else $error("Entry index out of range.");

   property p_busy_after_accept;
      @(posedge clock) disable iff (reset)
         req_tvalid && req_tready |=> !req_tready;
   endproperty
   assert property (p_busy_after_accept) else $error("Accepted during a scan.");

endmodule

bind rate_limited_wfq_picker rlwfq_checker u_rlwfq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- tb/sv/rate_limited_wfq_picker_tb.sv -----
`timescale 1ns / 1ps

module rate_limited_wfq_picker_tb;
   import rlwfq_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int BURST_HOLD  = 400;
   localparam int PHASES      = 12;
   localparam int PHASE_TICKS = 100;

   typedef logic [TABLE_W-1:0] table_type;

   typedef struct packed {
      logic             granted;
      logic [IDX_W-1:0] idx;
   } grant_type;

   class picker_model;
      table_type       inc_tbl;
      table_type       per_tbl;
      logic [TIME_W-1:0] finish_q[ENTRIES];
      logic [TIME_W-1:0] last_send[ENTRIES];
      logic            sent[ENTRIES];
      grant_type       pending_grants[$];
      int              errors;
      int              checked;

      function new();
         inc_tbl = INC_RESET;
         per_tbl = PERIOD_RESET;
         errors  = 0;
         checked = 0;
         for (int i = 0; i < ENTRIES; i++) begin
            finish_q[i]  = '0;
            last_send[i] = '0;
            sent[i]      = 1'b0;
         end
      endfunction

      function logic [TIME_W-1:0] slot(table_type t, int i);
         return TIME_W'(t[i*SLOT_BITS +: SLOT_BITS]);
      endfunction

      function void write_reg(csr_reg_type r, table_type v);
         case (r)
            REG_INCREMENT:  inc_tbl = v;
            REG_MIN_PERIOD: per_tbl = v;
            default: ;
         endcase
      endfunction

      function void note_tick(logic [TIME_W-1:0] now);
         logic              found;
         int                best;
         logic [TIME_W-1:0] elapsed;
         logic [TIME_W:0]   sum;
         grant_type         g;
         found = 1'b0;
         best  = 0;
         for (int i = 0; i < ENTRIES; i++) begin
            elapsed = now - last_send[i];
            if (!sent[i] || elapsed >= slot(per_tbl, i)) begin
               if (!found || finish_q[i] < finish_q[best]) begin
                  found = 1'b1;
                  best  = i;
               end
            end
         end
         if (found) begin
            sum = {1'b0, finish_q[best]} + {1'b0, slot(inc_tbl, best)};
            finish_q[best]  = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
            last_send[best] = now;
            sent[best]      = 1'b1;
         end
         g.granted = found;
         g.idx     = found ? IDX_W'(best) : '0;
         pending_grants.push_back(g);
      endfunction

      function void check_grant(logic [RSP_W-1:0] data);
         grant_type want;
         checked++;
         if (pending_grants.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result: granted=%0d index=%0d", data[0], data[IDX_W:1]);
            return;
         end
         want = pending_grants.pop_front();
         if (data[0] !== want.granted || data[IDX_W:1] !== want.idx) begin
            errors++;
            if (errors <= 10)
               $display("grant mismatch: expected granted=%0d index=%0d, got granted=%0d index=%0d",
                        want.granted, want.idx, data[0], data[IDX_W:1]);
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [TIME_W-1:0]  req_tdata;   // now_ms
   logic               rsp_tvalid;
   logic               rsp_tready;
   logic [RSP_W-1:0]   rsp_tdata;   // granted, entry_index[2:0], zero padding
   logic               csr_valid;
   logic               csr_ready;
   logic               csr_index;
   logic [TABLE_W-1:0] csr_data;

   picker_model model = new();
   bit          steady;
   bit          stall_burst_req;
   int          cycle_count;
   int          sent_items;

   rate_limited_wfq_picker u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            model.write_reg(csr_reg_type'(csr_index), csr_data);
         if (req_tvalid && req_tready)
            model.note_tick(req_tdata);
         if (rsp_tvalid && rsp_tready)
            model.check_grant(rsp_tdata);
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic table_type rand_table(int unsigned max);
      table_type t;
      t = '0;
      for (int i = 0; i < ENTRIES; i++)
         t[i*SLOT_BITS +: SLOT_BITS] = SLOT_BITS'($urandom_range(0, max));
      return t;
   endfunction

   function automatic logic [TIME_W-1:0] next_time(logic [TIME_W-1:0] t);
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return t + $urandom_range(0, 60);
      if (r < 85)
         return t + $urandom_range(0, 1100);
      if (r < 93)
         return $urandom;
      return t - $urandom_range(0, 500);
   endfunction

   task automatic send_tick(input logic [TIME_W-1:0] now);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= now;
      do @(posedge clock); while (!req_tready);
      sent_items++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (model.checked < sent_items)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_tables(input bit do_inc, input bit do_per,
                               input table_type inc, input table_type per);
      if (do_inc) begin
         csr_valid <= 1'b1;
         csr_index <= REG_INCREMENT;
         csr_data  <= inc;
         do @(posedge clock); while (!csr_ready);
      end
      if (do_per) begin
         csr_valid <= 1'b1;
         csr_index <= REG_MIN_PERIOD;
         csr_data  <= per;
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_burst_req) begin
            rsp_tready <= 1'b0;
            repeat (BURST_HOLD) @(posedge clock);
            stall_burst_req = 1'b0;
            rsp_tready <= 1'b1;
         end else if (!steady && $urandom_range(0, 99) < 25) begin
            rsp_tready <= 1'b0;
            repeat (1 + pick_gap()) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      logic [TIME_W-1:0] now;
      int                kind;
      cycle_count     = 0;
      sent_items      = 0;
      steady          = 1'b1;
      stall_burst_req = 1'b0;
      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      csr_valid       = 1'b0;
      csr_index       = REG_INCREMENT;
      csr_data        = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Fresh entries win in index order, then nothing is eligible, then a forward
      // jump of the clock makes every entry eligible again.
      for (int i = 0; i < ENTRIES; i++)
         send_tick(i);
      send_tick(32'd6);
      send_tick(32'hFFFF_FFFF);
      send_tick(32'h0000_0040);
      send_tick(32'h0000_0040);
      wait_idle();

      // Zero periods and zero increments: every entry always eligible, finish times unchanged.
      write_tables(1'b1, 1'b1, '0, '0);
      repeat (4) send_tick($urandom);
      wait_idle();

      // Largest increments and periods.
      write_tables(1'b1, 1'b1, '1, '1);
      send_tick(32'd0);
      send_tick(32'd1022);
      send_tick(32'd1023);
      send_tick(32'd2046);
      send_tick(32'h8000_0000);
      send_tick(32'h8000_03FF);
      wait_idle();

      now    = 32'd0;
      steady = 1'b0;
      for (int ph = 0; ph < PHASES; ph++) begin
         kind = ph % 6;
         case (kind)
            0: write_tables(1'b1, 1'b1, INC_RESET, PERIOD_RESET);
            1: write_tables(1'b1, 1'b1, rand_table(1023), rand_table(40));
            2: write_tables(1'b0, 1'b1, '0, rand_table(1023));
            3: write_tables(1'b1, 1'b1, table_type'({$urandom, $urandom}),
                            table_type'({$urandom, $urandom}));
            4: write_tables(1'b1, 1'b1, rand_table(64), rand_table(300));
            default: write_tables(1'b1, 1'b1, table_type'({$urandom, $urandom}), '0);
         endcase
         steady = (kind == 3);
         if (ph == 2 || ph == 8)
            stall_burst_req = 1'b1;
         for (int n = 0; n < PHASE_TICKS; n++) begin
            now = next_time(now);
            send_tick(now);
         end
         wait_idle();
      end

      if (model.errors == 0 && model.pending_grants.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
